@@ rtl/swmf_pkg.sv @@
package swmf_pkg;

   localparam int SAMPLE_W       = 16;  // sample and result word width
   localparam int CFG_W          = 4;   // window length register width
   localparam int SEEN_W         = 5;   // per-record sample counter width
   localparam int MAX_WINDOW_DEF = 15;  // default window store depth

   // per-cycle commands shared by every cell of the chain
   typedef struct packed {
      logic shift;  // new word enters, probes reload, rank counts clear
      logic step;   // rotate probes one cell and accumulate ranks
   } cell_ctrl_type;

endpackage

@@ rtl/swmf_cell.sv @@
// One window cell: holds a stored sample and a circulating probe, and
// counts how many probes fall below / at-or-below its own sample.
module swmf_cell #(
   parameter int CNT_W = 4
) (
   input  logic                                clock,
   input  swmf_pkg::cell_ctrl_type             ctrl,
   input  logic                                active,
   input  logic        [CNT_W-1:0]             half_w,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0] shift_in,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0] probe_in,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] sample,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] probe,
   output logic                                match
);
   import swmf_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] probe_ff;
   logic        [CNT_W-1:0]    less_ff;
   logic        [CNT_W-1:0]    leq_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         sample_ff <= shift_in;
         probe_ff  <= shift_in;
         less_ff   <= '0;
         leq_ff    <= '0;
      end else if (ctrl.step) begin
         probe_ff <= probe_in;
         if (active) begin
            if (probe_ff < sample_ff) begin
               less_ff <= less_ff + CNT_W'(1);
            end
            if (probe_ff <= sample_ff) begin
               leq_ff <= leq_ff + CNT_W'(1);
            end
         end
      end
   end

   // this sample's value is the middle order statistic
   assign match  = active && (less_ff <= half_w) && (leq_ff > half_w);
   assign sample = sample_ff;
   assign probe  = probe_ff;

endmodule

@@ rtl/sliding_window_median_filter.sv @@
// Channel  | Direction | Ports                                   | Moves
// req      | in        | req_valid req_stall req_sample req_last | one sample word
// rsp      | out       | rsp_valid rsp_stall rsp_value           | one result word
//          |           | rsp_end_of_record                       |
// csr      | in        | csr_write_enable csr_write_data         | window length
//
// Pass-through (even window): accept, then load result reg; req stalls until idle.
// Odd window with a median due: accept, rotate the probes around the w-cell chain,
// then load result reg. Trailing zeros on a last word: one per unstalled cycle.
// Reset is synchronous, clears control; window store contents are don't-care.
// A stalled rsp holds the result register and the block waits in emit.
module sliding_window_median_filter #(
   parameter int MAX_WINDOW = swmf_pkg::MAX_WINDOW_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                 req_last,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] rsp_value,
   output logic                                 rsp_end_of_record,
   input  logic                                 csr_write_enable,
   input  logic        [swmf_pkg::CFG_W-1:0]    csr_write_data
);
   import swmf_pkg::*;

   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int IDX_W   = $clog2(MAX_WINDOW);
   localparam int WIDE_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int CMP_W   = (CNT_W > SEEN_W) ? CNT_W : SEEN_W;
   localparam int CLAMP_W = (MAX_WINDOW - 1) | 1;  // largest odd window that fits
   localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

   typedef enum logic [1:0] {ST_IDLE, ST_SORT, ST_EMIT} state_type;

   state_type               state_ff;
   logic [CFG_W-1:0]        win_len_ff;
   logic [SEEN_W-1:0]       seen_ff;
   logic                    main_pend_ff;   // main (centered) result still owed
   logic                    main_med_ff;    // main result comes from the cells
   logic signed [SAMPLE_W-1:0] main_val_ff;
   logic [CNT_W-1:0]        zeros_ff;       // trailing zeros still owed
   logic                    last_ff;
   logic [CNT_W-1:0]        sort_cnt_ff;
   logic                    rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_value_ff;
   logic                    rsp_eor_ff;

   // window size decode
   logic [WIDE_W-1:0] wsz_wide;
   logic [WIDE_W-1:0] weff_wide;
   logic [CNT_W-1:0]  w_eff;
   logic [CNT_W-1:0]  half_w;
   logic              pass_thru;

   always_comb begin
      wsz_wide  = WIDE_W'(win_len_ff);
      weff_wide = (wsz_wide > WIDE_W'(MAX_WINDOW)) ? WIDE_W'(CLAMP_W) : wsz_wide;
      w_eff     = CNT_W'(weff_wide);
      half_w    = w_eff >> 1;
      pass_thru = !win_len_ff[0];
   end

   // per-word decisions at accept
   logic              req_accept;
   logic [SEEN_W-1:0] seen_c;
   logic [CMP_W-1:0]  c_wide;
   logic [CMP_W-1:0]  h_wide;
   logic [CMP_W-1:0]  w_wide;
   logic              has_main;
   logic              need_med;
   logic [CNT_W-1:0]  zeros_new;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      seen_c   = (seen_ff < SEEN_MAX) ? seen_ff + SEEN_W'(1) : SEEN_MAX;
      c_wide   = CMP_W'(seen_c);
      h_wide   = CMP_W'(half_w);
      w_wide   = CMP_W'(w_eff);
      has_main = pass_thru || (c_wide > h_wide);
      need_med = !pass_thru && (c_wide >= w_wide);
      if (pass_thru || !req_last) begin
         zeros_new = '0;
      end else if (c_wide > h_wide) begin
         zeros_new = half_w;
      end else begin
         zeros_new = CNT_W'(seen_c);  // short record: fits since c <= h
      end
   end

   // cell chain
   cell_ctrl_type              cell_ctrl;
   logic signed [SAMPLE_W-1:0] cell_sample [MAX_WINDOW];
   logic signed [SAMPLE_W-1:0] cell_probe  [MAX_WINDOW];
   logic        [MAX_WINDOW-1:0] cell_match;
   logic        [IDX_W-1:0]    wrap_idx;

   assign cell_ctrl.shift = req_accept;
   assign cell_ctrl.step  = (state_ff == ST_SORT);
   assign wrap_idx        = IDX_W'(w_eff - CNT_W'(1));  // probe ring closes at w-1

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic signed [SAMPLE_W-1:0] shift_src;
      logic signed [SAMPLE_W-1:0] probe_src;
      if (i == 0) begin : g_head
         assign shift_src = req_sample;
         assign probe_src = cell_probe[wrap_idx];
      end else begin : g_body
         assign shift_src = cell_sample[i-1];
         assign probe_src = cell_probe[i-1];
      end
      swmf_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .active   (CNT_W'(i) < w_eff),
         .half_w   (half_w),
         .shift_in (shift_src),
         .probe_in (probe_src),
         .sample   (cell_sample[i]),
         .probe    (cell_probe[i]),
         .match    (cell_match[i])
      );
   end

   // matching cells all hold the same value, so OR-merge is exact
   logic signed [SAMPLE_W-1:0] med_value;
   always_comb begin
      med_value = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         med_value = med_value | (cell_match[i] ? cell_sample[i] : '0);
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         win_len_ff     <= CFG_W'(1);
         seen_ff        <= '0;
         main_pend_ff   <= 1'b0;
         main_med_ff    <= 1'b0;
         zeros_ff       <= '0;
         last_ff        <= 1'b0;
         sort_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            win_len_ff <= csr_write_data;
         end
         // emit reloads the result register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  seen_ff      <= req_last ? '0 : seen_c;
                  main_pend_ff <= has_main;
                  main_med_ff  <= need_med;
                  main_val_ff  <= pass_thru ? req_sample : '0;
                  zeros_ff     <= zeros_new;
                  last_ff      <= req_last;
                  sort_cnt_ff  <= '0;
                  if (need_med) begin
                     state_ff <= ST_SORT;
                  end else if (has_main || zeros_new != '0) begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_SORT: begin
               sort_cnt_ff <= sort_cnt_ff + CNT_W'(1);
               if (sort_cnt_ff == w_eff - CNT_W'(1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (main_pend_ff) begin
                     rsp_value_ff <= main_med_ff ? med_value : main_val_ff;
                     rsp_eor_ff   <= last_ff && (zeros_ff == '0);
                     main_pend_ff <= 1'b0;
                     if (zeros_ff == '0) begin
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     rsp_value_ff <= '0;
                     rsp_eor_ff   <= last_ff && (zeros_ff == CNT_W'(1));
                     zeros_ff     <= zeros_ff - CNT_W'(1);
                     if (zeros_ff == CNT_W'(1)) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_end_of_record = rsp_eor_ff;

   // a median is about to be emitted: at least one cell must claim it
   a_med_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && main_pend_ff && main_med_ff) |-> (cell_match != '0))
      else $error("no cell holds the median");

   // trailing zeros are only owed for a last word
   a_zeros_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && zeros_ff != '0) |-> last_ff)
      else $error("trailing zeros without a last word");

   // probe rotation never runs past the window
   a_sort_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SORT) |-> (sort_cnt_ff < w_eff))
      else $error("sort step count overran the window");

   // emit state always owes something
   a_emit_owed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (main_pend_ff || zeros_ff != '0))
      else $error("emit state with nothing to send");

endmodule
